### design/m3i_pkg.sv
`default_nettype none
package m3i_pkg;

  // Element count and widths of the datapath.
  localparam int NE         = 9;
  localparam int W          = 32;
  localparam int CMAG_W     = 64;
  localparam int DET_W      = 98;
  localparam int MAGD_W     = 97;
  localparam int NUM_W      = 96;
  localparam int QB         = 33;
  localparam int CMP_W      = MAGD_W + QB;
  localparam int FRONT_STG  = 6;
  localparam int DIV_STG    = QB + 1;
  localparam int LAT        = FRONT_STG + DIV_STG + 1;

  typedef logic [NE-1:0][W-1:0] mat_t;

  // Cofactor j is a[w]*a[x] - a[y]*a[z], row-major element indexes.
  localparam int unsigned COF_IDX [NE][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // Source element of each result position when the output is transposed.
  localparam int unsigned TRANS_IDX [NE] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

  // What one divider lane hands to the merging stage.
  typedef struct packed {
    logic [QB-1:0] q;
    logic          ovf;
    logic          neg;
  } lane_res_t;

endpackage
`default_nettype wire

### design/m3i_in_if.sv
`default_nettype none
interface m3i_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, mode, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink (input valid, mode, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                output ready);
endinterface
`default_nettype wire

### design/m3i_out_if.sv
`default_nettype none
interface m3i_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic        singular;
  logic        saturated;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, saturated, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                singular, saturated, output ready);
endinterface
`default_nettype wire

### design/m3i_front.sv
`default_nettype none
module m3i_front (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   mode,
  input  m3i_pkg::mat_t                          a,
  output logic [m3i_pkg::NE-1:0][m3i_pkg::CMAG_W-1:0] mc,
  output logic [m3i_pkg::NE-1:0]                 neg,
  output logic [m3i_pkg::MAGD_W-1:0]             magd,
  output logic                                   dzero,
  output m3i_pkg::mat_t                          a_out
);
  import m3i_pkg::*;

  logic signed [2*W-1:0] pa1_r [NE];
  logic signed [2*W-1:0] pb1_r [NE];
  logic [CMAG_W-1:0]     cmag2_r [NE];
  logic [CMAG_W-1:0]     cmag3_r [NE];
  logic [CMAG_W-1:0]     cmag4_r [NE];
  logic [CMAG_W-1:0]     cmag5_r [NE];
  logic [NE-1:0]         cneg2_r, cneg3_r, cneg4_r, cneg5_r;
  logic [W-1:0]          amag2_r [3];
  logic [2:0]            aneg2_r, sg3_r;
  logic [2*W-1:0]        lo3_r [3];
  logic [2*W-1:0]        hi3_r [3];
  logic [DET_W-1:0]      term4_r [3];
  logic [DET_W-1:0]      det5_r;
  logic [CMAG_W-1:0]     mc6_r [NE];
  logic [NE-1:0]         neg6_r;
  logic [MAGD_W-1:0]     magd6_r;
  logic                  dzero6_r;
  mat_t                  a1_r, a2_r, a3_r, a4_r, a5_r, a6_r;
  logic                  m1_r, m2_r, m3_r, m4_r, m5_r;
  logic [2*W:0]          cdiff [NE];
  logic [NUM_W-1:0]      term [3];

  // Stage 1: the two products of every cofactor.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NE; j++) begin
        pa1_r[j] <= $signed(a[COF_IDX[j][0]]) * $signed(a[COF_IDX[j][1]]);
        pb1_r[j] <= $signed(a[COF_IDX[j][2]]) * $signed(a[COF_IDX[j][3]]);
      end
      a1_r <= a;
      m1_r <= mode;
    end
  end

  // Stage 2: cofactor differences, kept as sign and magnitude.
  always_comb begin
    for (int j = 0; j < NE; j++) begin
      cdiff[j] = {pa1_r[j][2*W-1], pa1_r[j]} - {pb1_r[j][2*W-1], pb1_r[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NE; j++) begin
        cmag2_r[j] <= cdiff[j][2*W] ? CMAG_W'(-cdiff[j]) : cdiff[j][CMAG_W-1:0];
        cneg2_r[j] <= cdiff[j][2*W];
      end
      for (int t = 0; t < 3; t++) begin
        amag2_r[t] <= a1_r[t][W-1] ? W'(-a1_r[t]) : a1_r[t];
        aneg2_r[t] <= a1_r[t][W-1];
      end
      a2_r <= a1_r;
      m2_r <= m1_r;
    end
  end

  // Stage 3: row 0 element times cofactor, split in two 32x32 partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 3; t++) begin
        lo3_r[t] <= amag2_r[t] * cmag2_r[3*t][W-1:0];
        hi3_r[t] <= amag2_r[t] * cmag2_r[3*t][CMAG_W-1:W];
        sg3_r[t] <= aneg2_r[t] ^ cneg2_r[3*t];
      end
      cmag3_r <= cmag2_r;
      cneg3_r <= cneg2_r;
      a3_r    <= a2_r;
      m3_r    <= m2_r;
    end
  end

  // Stage 4: recombine the partial products into signed terms.
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      term[t] = {hi3_r[t], {W{1'b0}}} + {{W{1'b0}}, lo3_r[t]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 3; t++) begin
        term4_r[t] <= sg3_r[t] ? -{2'b00, term[t]} : {2'b00, term[t]};
      end
      cmag4_r <= cmag3_r;
      cneg4_r <= cneg3_r;
      a4_r    <= a3_r;
      m4_r    <= m3_r;
    end
  end

  // Stage 5: determinant.
  always_ff @(posedge clk) begin
    if (en) begin
      det5_r  <= term4_r[0] + term4_r[1] + term4_r[2];
      cmag5_r <= cmag4_r;
      cneg5_r <= cneg4_r;
      a5_r    <= a4_r;
      m5_r    <= m4_r;
    end
  end

  // Stage 6: determinant magnitude, and each lane's cofactor in output order.
  always_ff @(posedge clk) begin
    if (en) begin
      magd6_r  <= det5_r[DET_W-1] ? MAGD_W'(-det5_r) : det5_r[MAGD_W-1:0];
      dzero6_r <= (det5_r == '0);
      for (int i = 0; i < NE; i++) begin
        mc6_r[i]  <= m5_r ? cmag5_r[TRANS_IDX[i]] : cmag5_r[i];
        neg6_r[i] <= (m5_r ? cneg5_r[TRANS_IDX[i]] : cneg5_r[i]) ^ det5_r[DET_W-1];
      end
      a6_r <= a5_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NE; i++) begin
      mc[i] = mc6_r[i];
    end
  end

  assign neg   = neg6_r;
  assign magd  = magd6_r;
  assign dzero = dzero6_r;
  assign a_out = a6_r;

endmodule
`default_nettype wire

### design/m3i_lane.sv
`default_nettype none
module m3i_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [m3i_pkg::CMAG_W-1:0]    mc,
  input  logic [m3i_pkg::MAGD_W-1:0]    magd,
  input  logic                          neg,
  output m3i_pkg::lane_res_t            res
);
  import m3i_pkg::*;

  logic [NUM_W-1:0]  rem_r [DIV_STG];
  logic [QB-1:0]     q_r   [DIV_STG];
  logic [MAGD_W-1:0] d_r   [DIV_STG];
  logic [DIV_STG-1:0] ovf_r, neg_r;
  logic [NUM_W-1:0]  num;

  // First stage: the numerator and the check for a quotient of 2^33 or more.
  assign num = {mc, {W{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      q_r[0]   <= '0;
      d_r[0]   <= magd;
      ovf_r[0] <= ({{(CMP_W-NUM_W){1'b0}}, num} >= {magd, {QB{1'b0}}});
      neg_r[0] <= neg;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 1; k < DIV_STG; k++) begin : g_step
    localparam int B = QB - k;
    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] rem_x;
    logic             ge;

    assign dsh   = {{QB{1'b0}}, d_r[k-1]} << B;
    assign rem_x = {{(CMP_W-NUM_W){1'b0}}, rem_r[k-1]};
    assign ge    = (rem_x >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? NUM_W'(rem_x - dsh) : rem_r[k-1];
        q_r[k]   <= q_r[k-1] | (QB'(ge) << B);
        d_r[k]   <= d_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign res.q   = q_r[DIV_STG-1];
  assign res.ovf = ovf_r[DIV_STG-1];
  assign res.neg = neg_r[DIV_STG-1];

endmodule
`default_nettype wire

### design/m3i_merge.sv
`default_nettype none
module m3i_merge (
  input  logic                                  clk,
  input  logic                                  en,
  input  m3i_pkg::lane_res_t [m3i_pkg::NE-1:0]  res,
  input  m3i_pkg::mat_t                         a,
  input  logic                                  dzero,
  output m3i_pkg::mat_t                         r,
  output logic                                  singular,
  output logic                                  saturated
);
  import m3i_pkg::*;

  logic [QB-1:0] lim [NE];
  logic [NE-1:0] sat;
  logic [W-1:0]  mag [NE];
  mat_t          val;
  mat_t          r_r;
  logic          sing_r, sat_r;

  // Clamp each quotient to the signed range and apply the sign.
  always_comb begin
    for (int i = 0; i < NE; i++) begin
      lim[i] = res[i].neg ? QB'(33'h0_8000_0000) : QB'(33'h0_7FFF_FFFF);
      sat[i] = res[i].ovf || (res[i].q > lim[i]);
      mag[i] = sat[i] ? lim[i][W-1:0] : res[i].q[W-1:0];
      val[i] = res[i].neg ? -mag[i] : mag[i];
    end
  end

  // A singular matrix comes back as it went in.
  always_ff @(posedge clk) begin
    if (en) begin
      r_r    <= dzero ? a : val;
      sing_r <= dzero;
      sat_r  <= !dzero && (|sat);
    end
  end

  assign r         = r_r;
  assign singular  = sing_r;
  assign saturated = sat_r;

endmodule
`default_nettype wire

### design/matrix3_inverse_unit.sv
// 3x3 inverse of a signed Q16.16 matrix by the adjugate method; mode 1 returns the
// transposed inverse. Every result element is cofactor * 2^32 / determinant, truncated
// toward zero and clamped to 32 bits (saturated flags a clamp); a zero determinant returns
// the input unchanged with singular set. The unit takes one matrix per clock unless the
// output stalls, and holds many in flight across the cofactor and determinant datapath,
// the nine parallel restoring dividers (a range check, then one quotient bit per stage for
// 33 stages) and the output register. The whole pipeline advances together, so a result
// left untaken at the output holds the input ready low until the result is taken.
`default_nettype none
module matrix3_inverse_unit (
  input  logic      clk,
  input  logic      rst_n,
  m3i_in_if.sink    in_ch,
  m3i_out_if.source out_ch
);
  import m3i_pkg::*;

  logic [LAT-1:0]    vld_r;
  logic              en;
  mat_t              a_in;
  mat_t              a_f;
  mat_t              r;
  logic [NE-1:0][CMAG_W-1:0] mc;
  logic [NE-1:0]     neg;
  logic [MAGD_W-1:0] magd;
  logic              dzero;
  lane_res_t [NE-1:0] res;
  mat_t              ad_r [DIV_STG];
  logic [DIV_STG-1:0] dz_r;
  logic              singular, saturated;

  // The pipeline moves whenever the output register is free or being emptied.
  assign en          = out_ch.ready || !vld_r[LAT-1];
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  assign a_in = {in_ch.a22, in_ch.a21, in_ch.a20, in_ch.a12, in_ch.a11, in_ch.a10,
                 in_ch.a02, in_ch.a01, in_ch.a00};

  m3i_front u_front (
    .clk   (clk),
    .en    (en),
    .mode  (in_ch.mode),
    .a     (a_in),
    .mc    (mc),
    .neg   (neg),
    .magd  (magd),
    .dzero (dzero),
    .a_out (a_f)
  );

  // Nine divider lanes, one per result element.
  for (genvar i = 0; i < NE; i++) begin : g_lane
    m3i_lane u_lane (
      .clk  (clk),
      .en   (en),
      .mc   (mc[i]),
      .magd (magd),
      .neg  (neg[i]),
      .res  (res[i])
    );
  end

  // The input matrix and the zero flag travel alongside the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      ad_r[0] <= a_f;
      dz_r[0] <= dzero;
      for (int k = 1; k < DIV_STG; k++) begin
        ad_r[k] <= ad_r[k-1];
        dz_r[k] <= dz_r[k-1];
      end
    end
  end

  m3i_merge u_merge (
    .clk       (clk),
    .en        (en),
    .res       (res),
    .a         (ad_r[DIV_STG-1]),
    .dzero     (dz_r[DIV_STG-1]),
    .r         (r),
    .singular  (singular),
    .saturated (saturated)
  );

  assign out_ch.valid     = vld_r[LAT-1];
  assign out_ch.r00       = r[0];
  assign out_ch.r01       = r[1];
  assign out_ch.r02       = r[2];
  assign out_ch.r10       = r[3];
  assign out_ch.r11       = r[4];
  assign out_ch.r12       = r[5];
  assign out_ch.r20       = r[6];
  assign out_ch.r21       = r[7];
  assign out_ch.r22       = r[8];
  assign out_ch.singular  = singular;
  assign out_ch.saturated = saturated;

  // A singular result never reports a clamp.
  a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.singular |-> !out_ch.saturated)
    else $error("singular result with saturated set");

  // A pending result that is not taken stalls the input side.
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  // An accepted transaction enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted transaction lost at entry");

endmodule
`default_nettype wire
